### hdl/tflp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Thermal fan level policy package
// Shared types and constants for the fan level policy block.
// ============================================================================
package tflp_pkg;

    localparam int TEMP_W = 20;
    localparam int THR_W  = 18;
    localparam int DUTY_W = 7;
    localparam int LVL_W  = 3;
    localparam int NUM_REGS = 8;
    localparam int IDX_W  = 3;
    // Working width for the signed temperature comparisons.
    localparam int CMP_W  = 22;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_F2B_MID  = 3'd0;
    localparam logic [IDX_W-1:0] REG_F2B_MAX  = 3'd1;
    localparam logic [IDX_W-1:0] REG_F2B_HIGH = 3'd2;
    localparam logic [IDX_W-1:0] REG_F2B_CRIT = 3'd3;
    localparam logic [IDX_W-1:0] REG_B2F_MID  = 3'd4;
    localparam logic [IDX_W-1:0] REG_B2F_MAX  = 3'd5;
    localparam logic [IDX_W-1:0] REG_B2F_HIGH = 3'd6;
    localparam logic [IDX_W-1:0] REG_B2F_CRIT = 3'd7;

    // Register reset values in millidegrees.
    localparam logic [THR_W-1:0] RST_F2B_MID  = 18'd38000;
    localparam logic [THR_W-1:0] RST_F2B_MAX  = 18'd46000;
    localparam logic [THR_W-1:0] RST_F2B_HIGH = 18'd58000;
    localparam logic [THR_W-1:0] RST_F2B_CRIT = 18'd66000;
    localparam logic [THR_W-1:0] RST_B2F_MID  = 18'd34000;
    localparam logic [THR_W-1:0] RST_B2F_MAX  = 18'd44000;
    localparam logic [THR_W-1:0] RST_B2F_HIGH = 18'd59000;
    localparam logic [THR_W-1:0] RST_B2F_CRIT = 18'd67000;

    // Thermal levels.
    localparam logic [LVL_W-1:0] LVL_DEFAULT = 3'd0;
    localparam logic [LVL_W-1:0] LVL_MID     = 3'd1;
    localparam logic [LVL_W-1:0] LVL_MAX     = 3'd2;
    localparam logic [LVL_W-1:0] LVL_HIGH    = 3'd3;
    localparam logic [LVL_W-1:0] LVL_CRIT    = 3'd4;

    // Duty settings in percent.
    localparam logic [DUTY_W-1:0] DUTY_DEFAULT = 7'd38;
    localparam logic [DUTY_W-1:0] DUTY_MID     = 7'd63;
    localparam logic [DUTY_W-1:0] DUTY_FULL    = 7'd100;

    localparam logic signed [CMP_W-1:0] CLEAR_MARGIN = 22'sd5000;
    localparam logic signed [CMP_W-1:0] TOP_BOUND    = 22'sd200000;

    typedef logic [NUM_REGS-1:0][THR_W-1:0] thr_bank_t;

    // One poll as held in the input register; fan health is already reduced.
    typedef struct packed {
        logic                     front_to_back;
        logic                     sensor_a_ok;
        logic signed [TEMP_W-1:0] sensor_a_temp;
        logic                     sensor_b_ok;
        logic signed [TEMP_W-1:0] sensor_b_temp;
        logic [DUTY_W-1:0]        present_duty;
        logic                     fans_ok;
    } poll_t;

    typedef struct packed {
        logic [LVL_W-1:0] thermal_level;
        logic             alarm_latched;
        logic             fan_failed;
    } policy_state_t;

    typedef struct packed {
        logic              status;
        logic              write_duty;
        logic [DUTY_W-1:0] duty_percent;
        logic [LVL_W-1:0]  level;
        logic              alarm_raised;
        logic              alarm_cleared;
        logic              alarm_active;
        logic              shutdown;
    } result_t;

endpackage
`default_nettype wire

### hdl/tflp_poll_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Poll channel interface
// Valid/ready channel carrying one sensor and fan poll per beat.
// ============================================================================
interface tflp_poll_if #(
    parameter int NUM_FANS = 6
);
    logic                                       valid;
    logic                                       ready;
    logic                                       front_to_back;
    logic                                       sensor_a_ok;
    logic signed [tflp_pkg::TEMP_W-1:0]         sensor_a_temp;
    logic                                       sensor_b_ok;
    logic signed [tflp_pkg::TEMP_W-1:0]         sensor_b_temp;
    logic [tflp_pkg::DUTY_W-1:0]                present_duty;
    logic [NUM_FANS-1:0]                        fans_healthy;

    modport source (
        output valid, front_to_back, sensor_a_ok, sensor_a_temp,
               sensor_b_ok, sensor_b_temp, present_duty, fans_healthy,
        input  ready
    );

    modport sink (
        input  valid, front_to_back, sensor_a_ok, sensor_a_temp,
               sensor_b_ok, sensor_b_temp, present_duty, fans_healthy,
        output ready
    );
endinterface
`default_nettype wire

### hdl/tflp_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Result channel interface
// Valid/ready channel carrying one policy decision per beat.
// ============================================================================
interface tflp_result_if;
    logic                          valid;
    logic                          ready;
    logic                          status;
    logic                          write_duty;
    logic [tflp_pkg::DUTY_W-1:0]   duty_percent;
    logic [tflp_pkg::LVL_W-1:0]    level;
    logic                          alarm_raised;
    logic                          alarm_cleared;
    logic                          alarm_active;
    logic                          shutdown;

    modport source (
        output valid, status, write_duty, duty_percent, level,
               alarm_raised, alarm_cleared, alarm_active, shutdown,
        input  ready
    );

    modport sink (
        input  valid, status, write_duty, duty_percent, level,
               alarm_raised, alarm_cleared, alarm_active, shutdown,
        output ready
    );
endinterface
`default_nettype wire

### hdl/tflp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Threshold register bank
// Eight writable 18-bit temperature thresholds with their reset values.
// ============================================================================
module tflp_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tflp_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [tflp_pkg::THR_W-1:0]     cfg_data,
    output tflp_pkg::thr_bank_t                 thresholds
);

    tflp_pkg::thr_bank_t thr_reg;
    tflp_pkg::thr_bank_t thr_next;

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tflp_pkg::REG_F2B_MID:  thr_next[tflp_pkg::REG_F2B_MID]  = cfg_data;
                tflp_pkg::REG_F2B_MAX:  thr_next[tflp_pkg::REG_F2B_MAX]  = cfg_data;
                tflp_pkg::REG_F2B_HIGH: thr_next[tflp_pkg::REG_F2B_HIGH] = cfg_data;
                tflp_pkg::REG_F2B_CRIT: thr_next[tflp_pkg::REG_F2B_CRIT] = cfg_data;
                tflp_pkg::REG_B2F_MID:  thr_next[tflp_pkg::REG_B2F_MID]  = cfg_data;
                tflp_pkg::REG_B2F_MAX:  thr_next[tflp_pkg::REG_B2F_MAX]  = cfg_data;
                tflp_pkg::REG_B2F_HIGH: thr_next[tflp_pkg::REG_B2F_HIGH] = cfg_data;
                tflp_pkg::REG_B2F_CRIT: thr_next[tflp_pkg::REG_B2F_CRIT] = cfg_data;
                default:                thr_next = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg[tflp_pkg::REG_F2B_MID]  <= tflp_pkg::RST_F2B_MID;
            thr_reg[tflp_pkg::REG_F2B_MAX]  <= tflp_pkg::RST_F2B_MAX;
            thr_reg[tflp_pkg::REG_F2B_HIGH] <= tflp_pkg::RST_F2B_HIGH;
            thr_reg[tflp_pkg::REG_F2B_CRIT] <= tflp_pkg::RST_F2B_CRIT;
            thr_reg[tflp_pkg::REG_B2F_MID]  <= tflp_pkg::RST_B2F_MID;
            thr_reg[tflp_pkg::REG_B2F_MAX]  <= tflp_pkg::RST_B2F_MAX;
            thr_reg[tflp_pkg::REG_B2F_HIGH] <= tflp_pkg::RST_B2F_HIGH;
            thr_reg[tflp_pkg::REG_B2F_CRIT] <= tflp_pkg::RST_B2F_CRIT;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign thresholds = thr_reg;

endmodule
`default_nettype wire

### hdl/tflp_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Fan level decision logic
// Averages the readings, picks the level and decides duty, alarm and shutdown.
// ============================================================================
module tflp_core (
    input  tflp_pkg::poll_t          poll,
    input  tflp_pkg::policy_state_t  state,
    input  tflp_pkg::thr_bank_t      thresholds,
    output tflp_pkg::result_t        result,
    output tflp_pkg::policy_state_t  state_next
);

    localparam int CW = tflp_pkg::CMP_W;

    logic signed [CW-1:0]      temp_sum;
    logic signed [CW-1:0]      temp_avg;
    logic signed [CW-1:0]      bound [6];
    logic [4:0]                in_band;
    logic [tflp_pkg::LVL_W-1:0] lvl;
    logic [tflp_pkg::DUTY_W-1:0] lvl_duty;
    logic                      raise;
    logic                      alarm_set;
    logic                      clear;
    logic                      changed;

    always_comb
    begin
        // Sum of the two readings, then halve rounding toward zero.
        temp_sum = CW'(poll.sensor_a_temp) + CW'(poll.sensor_b_temp);
        temp_avg = (temp_sum + $signed(CW'({1'b0, temp_sum[CW-1]}))) >>> 1;

        bound[0] = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (poll.front_to_back)
            begin
                bound[i+1] = CW'(thresholds[i]);
            end
            else
            begin
                bound[i+1] = CW'(thresholds[i+4]);
            end
        end
        bound[5] = tflp_pkg::TOP_BOUND;

        for (int i = 0; i < 5; i++)
        begin
            in_band[i] = (temp_avg > bound[i]) && (temp_avg <= bound[i+1]);
        end

        // The highest band that holds the average wins.
        lvl = tflp_pkg::LVL_DEFAULT;
        for (int i = 0; i < 5; i++)
        begin
            if (in_band[i])
            begin
                lvl = tflp_pkg::LVL_W'(i);
            end
        end

        case (lvl)
            tflp_pkg::LVL_DEFAULT: lvl_duty = tflp_pkg::DUTY_DEFAULT;
            tflp_pkg::LVL_MID:     lvl_duty = tflp_pkg::DUTY_MID;
            default:               lvl_duty = tflp_pkg::DUTY_FULL;
        endcase

        changed   = (lvl != state.thermal_level);
        raise     = changed && (lvl == tflp_pkg::LVL_HIGH)
                    && (state.thermal_level < tflp_pkg::LVL_HIGH) && !state.alarm_latched;
        alarm_set = state.alarm_latched || raise;
        clear     = alarm_set && (lvl < tflp_pkg::LVL_HIGH)
                    && (temp_avg < (bound[3] - tflp_pkg::CLEAR_MARGIN));

        result = '0;
        state_next = state;
        if (!poll.sensor_a_ok || !poll.sensor_b_ok)
        begin
            result.status       = 1'b1;
            result.write_duty   = 1'b1;
            result.duty_percent = tflp_pkg::DUTY_MID;
            result.level        = state.thermal_level;
            result.alarm_active = state.alarm_latched;
        end
        else
        begin
            if (!state.fan_failed && (poll.present_duty != lvl_duty))
            begin
                result.write_duty   = 1'b1;
                result.duty_percent = lvl_duty;
            end
            if (!poll.fans_ok)
            begin
                result.write_duty   = 1'b1;
                result.duty_percent = tflp_pkg::DUTY_FULL;
            end
            result.level         = lvl;
            result.alarm_raised  = raise;
            result.alarm_cleared = clear;
            result.alarm_active  = alarm_set && !clear;
            result.shutdown      = changed && (lvl == tflp_pkg::LVL_CRIT);

            state_next.thermal_level = lvl;
            state_next.alarm_latched = alarm_set && !clear;
            state_next.fan_failed    = !poll.fans_ok;
        end
    end

endmodule
`default_nettype wire

### hdl/thermal_fan_level_policy_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A poll beat accepted into the input register is turned into a result in the result
// register, from which the result beat is offered; a busy consumer can hold it there.
// Throughput: one poll per cycle unless the consumer stalls; the input register and
// result register form a two-stage pipeline, its only loop the policy state update.
// Reset (rst_n, asynchronous, active low): both stages empty, thermal level 0,
// alarm and fan-failure flags clear, thresholds back to their default values.
// ============================================================================
// Thermal fan level policy top level
// Decides fan duty, thermal level, alarm and shutdown from each sensor poll.
// ============================================================================
module thermal_fan_level_policy_top #(
    parameter int NUM_FANS = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [tflp_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [tflp_pkg::THR_W-1:0]  cfg_data,
    tflp_poll_if.sink                        poll,
    tflp_result_if.source                    result
);

    // Stage one holds the accepted poll; stage two holds the finished result.
    // Each stage advances when the stage after it is empty or being drained,
    // so a new beat is taken every cycle while the consumer keeps up.
    tflp_pkg::poll_t          poll_reg;
    logic                     poll_valid_reg;
    tflp_pkg::result_t        res_reg;
    logic                     res_valid_reg;
    tflp_pkg::policy_state_t  state_reg;

    tflp_pkg::thr_bank_t      thresholds;
    tflp_pkg::result_t        res_next;
    tflp_pkg::policy_state_t  state_next;
    tflp_pkg::poll_t          poll_next;

    logic res_advance;
    logic poll_advance;

    // The result stage can load when it is empty or its beat leaves now.
    assign res_advance  = !res_valid_reg || result.ready;
    // The poll stage can load when it is empty or its poll moves on now.
    assign poll_advance = !poll_valid_reg || res_advance;
    assign poll.ready   = poll_advance;

    // Fan health is reduced to one flag as the poll is captured; only the
    // fitted fans are looked at.
    always_comb
    begin
        poll_next.front_to_back = poll.front_to_back;
        poll_next.sensor_a_ok   = poll.sensor_a_ok;
        poll_next.sensor_a_temp = poll.sensor_a_temp;
        poll_next.sensor_b_ok   = poll.sensor_b_ok;
        poll_next.sensor_b_temp = poll.sensor_b_temp;
        poll_next.present_duty  = poll.present_duty;
        poll_next.fans_ok       = &poll.fans_healthy[NUM_FANS-1:0];
    end

    tflp_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .thresholds (thresholds)
    );

    tflp_core u_core (
        .poll       (poll_reg),
        .state      (state_reg),
        .thresholds (thresholds),
        .result     (res_next),
        .state_next (state_next)
    );

    // Control and policy state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (poll_advance)
            begin
                poll_valid_reg <= poll.valid;
            end
            if (res_advance)
            begin
                res_valid_reg <= poll_valid_reg;
                // The policy state moves only when a poll is turned into a result,
                // so the next poll in line already sees the updated state.
                if (poll_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (poll_advance && poll.valid)
        begin
            poll_reg <= poll_next;
        end
        if (res_advance && poll_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.status        = res_reg.status;
    assign result.write_duty    = res_reg.write_duty;
    assign result.duty_percent  = res_reg.duty_percent;
    assign result.level         = res_reg.level;
    assign result.alarm_raised  = res_reg.alarm_raised;
    assign result.alarm_cleared = res_reg.alarm_cleared;
    assign result.alarm_active  = res_reg.alarm_active;
    assign result.shutdown      = res_reg.shutdown;

endmodule
`default_nettype wire
